>>> rtl/dvrt_pkg.sv
`timescale 1ns / 1ps

package dvrt_pkg;

	localparam int DEST_W    = 4;
	localparam int COST_W    = 24;
	localparam int PORT_W    = 3;
	localparam int PORTS     = 8;
	localparam int NC_W      = 5;
	localparam int SELF_W    = 4;
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 1;
	// Wide enough for any table depth and for the node count.
	localparam int SPAN_W    = 9;

	localparam logic [COST_W-1:0] COST_INF = '1;

	localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SELF_INDEX = 1'd1;

	localparam logic KIND_VECTOR  = 1'b0;
	localparam logic KIND_READOUT = 1'b1;

	typedef struct packed {
		logic [COST_W-1:0] cost;
		logic [PORT_W-1:0] port;
	} dvrt_route_t;

endpackage

>>> rtl/dvrt_in_if.sv
`timescale 1ns / 1ps

interface dvrt_in_if import dvrt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              kind;
	logic [DEST_W-1:0] destination;
	logic [COST_W-1:0] neighbor_cost;
	logic [COST_W-1:0] link_cost;
	logic [PORT_W-1:0] arrival_port;
	logic              last;

	modport source (
		output valid, kind, destination, neighbor_cost, link_cost, arrival_port, last,
		input  ready
	);
	modport sink (
		input  valid, kind, destination, neighbor_cost, link_cost, arrival_port, last,
		output ready
	);
endinterface

>>> rtl/dvrt_out_if.sv
`timescale 1ns / 1ps

interface dvrt_out_if import dvrt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DEST_W-1:0] route_dest;
	logic [COST_W-1:0] route_cost;
	logic [PORT_W-1:0] next_port;
	logic              has_next_hop;
	logic              table_changed;
	logic              end_of_run;

	modport source (
		output valid, route_dest, route_cost, next_port, has_next_hop, table_changed,
		       end_of_run,
		input  ready
	);
	modport sink (
		input  valid, route_dest, route_cost, next_port, has_next_hop, table_changed,
		       end_of_run,
		output ready
	);
endinterface

>>> rtl/dvrt_store.sv
`timescale 1ns / 1ps

module dvrt_store import dvrt_pkg::*; #(
	parameter int NODES = 16,
	parameter int IDX_W = $clog2(NODES)
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output dvrt_route_t rd_data,
	output logic        rd_valid,
	input  logic        wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  dvrt_route_t wr_data
);

	dvrt_route_t mem [NODES];
	dvrt_route_t rd_data_q;
	logic [NODES-1:0] vld_q;
	logic rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// An entry never written reads as unreachable through its cleared valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data  = rd_data_q;
	assign rd_valid = rd_vld_q;

endmodule

>>> rtl/distance_vector_route_table.sv
`timescale 1ns / 1ps

// Distance-vector route table: one cost and next-hop port per destination, kept in a
// synchronous table with one read and one write port. A vector entry is read from the
// table as it is accepted, then compared and written back only when the new cost is
// lower; an entry marked last then hands over its table_changed result in a close step.
// A readout steps through the destinations in use, with a table read and then a
// result transfer for each. Both wait while the result register is full and not taken.
// The table needs no clearing pass after reset.

module distance_vector_route_table import dvrt_pkg::*; #(
	parameter int NODES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	dvrt_in_if.sink              entry,
	dvrt_out_if.source           route
);

	localparam int IDX_W = $clog2(NODES);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_CLOSE,
		ST_RD_ISSUE,
		ST_RD_EMIT
	} state_t;

	state_t state_q;
	logic [NC_W-1:0]   node_count_q;
	logic [SELF_W-1:0] self_index_q;
	logic [NC_W-1:0]   cnt_q;
	logic              flag_q;
	logic              out_valid_q;

	logic [DEST_W-1:0] dest_q;
	logic [COST_W-1:0] ncost_q;
	logic [COST_W-1:0] lcost_q;
	logic [PORT_W-1:0] port_q;
	logic              last_q;

	logic [DEST_W-1:0] out_dest_q;
	logic [COST_W-1:0] out_cost_q;
	logic [PORT_W-1:0] out_port_q;
	logic              out_hop_q;
	logic              out_chg_q;
	logic              out_eor_q;

	logic [SPAN_W-1:0] used_n;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	dvrt_route_t       rd_data;
	logic              rd_valid;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	dvrt_route_t       wr_data;

	logic [COST_W:0]   sum;
	logic [COST_W-1:0] sat_cost;
	logic [COST_W-1:0] cur_cost;
	logic              eligible;
	logic              out_free;
	logic              load_close;
	logic              load_rd;
	logic              is_self;
	logic              rd_last;
	logic [COST_W-1:0] rd_cost;
	logic [PORT_W-1:0] rd_port;

	always_comb begin
		if (node_count_q == '0) begin
			used_n = SPAN_W'(1);
		end else if (SPAN_W'(node_count_q) > SPAN_W'(NODES)) begin
			used_n = SPAN_W'(NODES);
		end else begin
			used_n = SPAN_W'(node_count_q);
		end
	end

	assign entry.ready = (state_q == ST_IDLE);
	assign out_free    = !out_valid_q || route.ready;

	// The table is read at the accept edge so that the update step sees the entry.
	assign rd_en   = (state_q == ST_IDLE && entry.valid) || state_q == ST_RD_ISSUE;
	assign rd_addr = (state_q == ST_RD_ISSUE) ? IDX_W'(SPAN_W'(cnt_q))
	                                          : IDX_W'(SPAN_W'(entry.destination));

	assign sum      = {1'b0, lcost_q} + {1'b0, ncost_q};
	assign sat_cost = sum[COST_W] ? COST_INF : sum[COST_W-1:0];
	assign cur_cost = rd_valid ? rd_data.cost : COST_INF;
	assign eligible = (SPAN_W'(dest_q) < used_n) && (dest_q != self_index_q) &&
	                  (SPAN_W'(port_q) < SPAN_W'(PORTS)) && (ncost_q != COST_INF);

	assign wr_en        = (state_q == ST_UPDATE) && eligible && (sat_cost < cur_cost);
	assign wr_addr      = IDX_W'(SPAN_W'(dest_q));
	assign wr_data.cost = sat_cost;
	assign wr_data.port = port_q;

	assign is_self = (cnt_q == NC_W'(self_index_q));
	assign rd_last = (SPAN_W'(cnt_q) + SPAN_W'(1)) == used_n;
	assign rd_cost = is_self ? '0 : cur_cost;
	assign rd_port = (is_self || !rd_valid) ? '0 : rd_data.port;

	assign load_close = (state_q == ST_CLOSE) && out_free;
	assign load_rd    = (state_q == ST_RD_EMIT) && out_free;

	dvrt_store #(
		.NODES (NODES),
		.IDX_W (IDX_W)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.rd_valid (rd_valid),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			node_count_q <= NC_W'(16);
			self_index_q <= '0;
			cnt_q        <= '0;
			flag_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_NODE_COUNT: node_count_q <= cfg_data;
					CFG_SELF_INDEX: self_index_q <= cfg_data[SELF_W-1:0];
					default: ;
				endcase
			end
			if (load_close || load_rd) begin
				out_valid_q <= 1'b1;
			end else if (route.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (entry.valid) begin
						cnt_q   <= '0;
						state_q <= (entry.kind == KIND_READOUT) ? ST_RD_ISSUE : ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					flag_q  <= flag_q | wr_en;
					state_q <= last_q ? ST_CLOSE : ST_IDLE;
				end
				ST_CLOSE: begin
					if (out_free) begin
						flag_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				ST_RD_ISSUE: begin
					state_q <= ST_RD_EMIT;
				end
				ST_RD_EMIT: begin
					if (out_free) begin
						cnt_q   <= cnt_q + NC_W'(1);
						state_q <= rd_last ? ST_IDLE : ST_RD_ISSUE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && entry.valid) begin
			dest_q  <= entry.destination;
			ncost_q <= entry.neighbor_cost;
			lcost_q <= entry.link_cost;
			port_q  <= entry.arrival_port;
			last_q  <= entry.last;
		end
		if (load_close) begin
			out_dest_q <= '0;
			out_cost_q <= '0;
			out_port_q <= '0;
			out_hop_q  <= 1'b0;
			out_chg_q  <= flag_q;
			out_eor_q  <= 1'b1;
		end else if (load_rd) begin
			out_dest_q <= cnt_q[DEST_W-1:0];
			out_cost_q <= rd_cost;
			out_port_q <= rd_port;
			out_hop_q  <= !is_self && (rd_cost != COST_INF);
			out_chg_q  <= 1'b0;
			out_eor_q  <= rd_last;
		end
	end

	assign route.valid         = out_valid_q;
	assign route.route_dest    = out_dest_q;
	assign route.route_cost    = out_cost_q;
	assign route.next_port     = out_port_q;
	assign route.has_next_hop  = out_hop_q;
	assign route.table_changed = out_chg_q;
	assign route.end_of_run    = out_eor_q;

endmodule

>>> rtl/dvrt_checker.sv
`timescale 1ns / 1ps

module dvrt_checker import dvrt_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [DEST_W-1:0] route_dest,
	input logic [COST_W-1:0] route_cost,
	input logic              has_next_hop,
	input logic              table_changed,
	input logic              end_of_run
);

	// Items are worked one at a time, so a transfer in closes the input until that item is done.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while the previous item is at work");

	a_change_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !end_of_run |-> !table_changed)
		else $error("table_changed set inside a readout burst");

	a_hop_is_reachable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && has_next_hop |-> route_cost != COST_INF)
		else $error("next hop reported for an unreachable destination");

	a_close_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_changed |-> route_cost == '0 && route_dest == '0 && !has_next_hop)
		else $error("vector close result carries route fields");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(route_cost) && $stable(route_dest))
		else $error("stalled result changed");

endmodule

bind distance_vector_route_table dvrt_checker u_dvrt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (entry.valid),
	.in_ready      (entry.ready),
	.out_valid     (route.valid),
	.out_ready     (route.ready),
	.route_dest    (route.route_dest),
	.route_cost    (route.route_cost),
	.has_next_hop  (route.has_next_hop),
	.table_changed (route.table_changed),
	.end_of_run    (route.end_of_run)
);
